// File: sv/tlpt_pkg.sv
`timescale 1ns / 1ps
// tlpt_pkg: types and fixed widths for the two-level page table engine
// no dependencies; imported by two_level_page_table

package tlpt_pkg;

   // field widths of the request and response beats
   localparam int VA_W    = 26;
   localparam int PA_W    = 32;
   localparam int FLAG_W  = 12;
   localparam int OFF_W   = 12;
   localparam int VPN_W   = VA_W - OFF_W;
   localparam int FRAME_W = PA_W - OFF_W;

   // flag bit positions
   localparam int FLAG_PRESENT = 0;
   localparam int FLAG_USER    = 2;

   // shared multiplier: variable operand is a page number, quotient or directory index, constant operand below
   localparam int MUL_B_W = VPN_W + 2;
   localparam int PROD_W  = VPN_W + MUL_B_W;

   typedef enum logic [1:0] {
      ACT_MAP   = 2'd0,
      ACT_UNMAP = 2'd1,
      ACT_XLATE = 2'd2,
      ACT_QUERY = 2'd3
   } action_type;

   // the only flag bits that are ever read back
   typedef struct packed {
      logic user;
      logic present;
   } perm_type;

   // stored table entry: frame plus the permission bits
   typedef struct packed {
      logic [FRAME_W-1:0] frame;
      perm_type           perm;
   } entry_type;

endpackage

// File: sv/two_level_page_table.sv
`timescale 1ns / 1ps
// two_level_page_table: page directory and page table engine, one module
// depends on tlpt_pkg
//
// Usage: one request beat carries an action (map, unmap, translate, user query),
// a 26-bit virtual address, a physical page and 12 flag bits. Map and unmap give
// no response beat; translate and query give one beat each (phys_addr or
// user_mapped, the other field zero).
// The page number is split into directory and table index by a single shared
// multiplier (reciprocal multiply, then remainder), which also forms the table
// memory address; a small one-hot sequencer steps it over five products.
// Lookups then read the directory memory and the table memory one after the
// other. A translate or query forms its response once the table entry is in;
// a map or unmap returns to idle after the entry write, with a clear of the new
// table before it when it has to create the table (one table memory write per
// cycle to clear it).
// One request is in flight at a time; req_ready is high only when idle.
// After reset the directory memory is swept to not present, one entry per cycle,
// so req_ready stays low until the sweep ends.
// The response sits in an output register; if the receiver stalls, a finished
// lookup waits in its last step until that register frees up.

module two_level_page_table
   import tlpt_pkg::*;
#(
   parameter int DIR_ENTRIES   = 16,
   parameter int TABLE_ENTRIES = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_action,
   input  logic [VA_W-1:0]   req_virt_addr,
   input  logic [PA_W-1:0]   req_phys_page,
   input  logic [FLAG_W-1:0] req_flags,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [PA_W-1:0]   rsp_phys_addr,
   output logic              rsp_user_mapped
);

   // index widths and memory depth
   localparam int TAB_W     = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int DIR_W     = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;
   localparam int TBL_DEPTH = DIR_ENTRIES * TABLE_ENTRIES;
   localparam int ADDR_W    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

   // reciprocals: floor(n / k) == (n * ceil(2^s / k)) >> s for any VPN_W-bit n
   localparam int T_SHIFT = VPN_W + $clog2(TABLE_ENTRIES);
   localparam int D_SHIFT = VPN_W + $clog2(DIR_ENTRIES);
   localparam int T_RECIP = ((1 << T_SHIFT) + TABLE_ENTRIES - 1) / TABLE_ENTRIES;
   localparam int D_RECIP = ((1 << D_SHIFT) + DIR_ENTRIES - 1) / DIR_ENTRIES;

   localparam logic [MUL_B_W-1:0] T_RECIP_C = MUL_B_W'(T_RECIP);
   localparam logic [MUL_B_W-1:0] D_RECIP_C = MUL_B_W'(D_RECIP);
   localparam logic [MUL_B_W-1:0] T_CNT_C   = MUL_B_W'(TABLE_ENTRIES);
   localparam logic [MUL_B_W-1:0] D_CNT_C   = MUL_B_W'(DIR_ENTRIES);
   localparam logic [TAB_W-1:0]   TAB_LAST  = TAB_W'(TABLE_ENTRIES - 1);
   localparam logic [DIR_W-1:0]   DIR_LAST  = DIR_W'(DIR_ENTRIES - 1);

   typedef enum logic [10:0] {
      S_INIT  = 11'b000_0000_0001,
      S_IDLE  = 11'b000_0000_0010,
      S_DIV1  = 11'b000_0000_0100,
      S_REM1  = 11'b000_0000_1000,
      S_DIV2  = 11'b000_0001_0000,
      S_REM2  = 11'b000_0010_0000,
      S_ADDR  = 11'b000_0100_0000,
      S_LOOK  = 11'b000_1000_0000,
      S_TRD   = 11'b001_0000_0000,
      S_CLEAR = 11'b010_0000_0000,
      S_WRITE = 11'b100_0000_0000
   } state_type;

   // control registers
   state_type            state_ff, state_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DIR_W-1:0]     init_ptr_ff, init_ptr_in;

   // request and working registers
   action_type           act_ff, act_in;
   logic [VPN_W-1:0]     vpn_ff, vpn_in;
   logic [OFF_W-1:0]     off_ff, off_in;
   logic [FRAME_W-1:0]   frame_ff, frame_in;
   perm_type             perm_ff, perm_in;
   logic [VPN_W-1:0]     q1_ff, q1_in;
   logic [VPN_W-1:0]     q2_ff, q2_in;
   logic [TAB_W-1:0]     tab_ff, tab_in;
   logic [DIR_W-1:0]     dir_ff, dir_in;
   logic [ADDR_W-1:0]    addr_ff, addr_in;
   logic [ADDR_W-1:0]    clr_ptr_ff, clr_ptr_in;
   logic [TAB_W-1:0]     clr_cnt_ff, clr_cnt_in;
   logic [PA_W-1:0]      rsp_pa_ff, rsp_pa_in;
   logic                 rsp_um_ff, rsp_um_in;

   // shared multiplier
   logic [VPN_W-1:0]     mul_a;
   logic [MUL_B_W-1:0]   mul_b;
   logic [PROD_W-1:0]    prod;
   logic [VPN_W-1:0]     diff;
   logic [ADDR_W-1:0]    base;

   // memories and their ports
   perm_type             dir_mem [DIR_ENTRIES];
   entry_type            tbl_mem [TBL_DEPTH];
   perm_type             dir_rd_ff;
   entry_type            tbl_rd_ff;
   logic                 dir_we, dir_re;
   logic [DIR_W-1:0]     dir_wa;
   perm_type             dir_wd;
   logic                 tbl_we, tbl_re;
   logic [ADDR_W-1:0]    tbl_wa;
   entry_type            tbl_wd;
   logic                 hit;

   assign prod      = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign diff      = vpn_ff - prod[VPN_W-1:0];
   assign base      = prod[ADDR_W-1:0];
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_phys_addr   = rsp_pa_ff;
   assign rsp_user_mapped = rsp_um_ff;

   // sequencer and datapath next values
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      init_ptr_in  = init_ptr_ff;
      act_in       = act_ff;
      vpn_in       = vpn_ff;
      off_in       = off_ff;
      frame_in     = frame_ff;
      perm_in      = perm_ff;
      q1_in        = q1_ff;
      q2_in        = q2_ff;
      tab_in       = tab_ff;
      dir_in       = dir_ff;
      addr_in      = addr_ff;
      clr_ptr_in   = clr_ptr_ff;
      clr_cnt_in   = clr_cnt_ff;
      rsp_pa_in    = rsp_pa_ff;
      rsp_um_in    = rsp_um_ff;
      mul_a        = '0;
      mul_b        = '0;
      dir_we       = 1'b0;
      dir_re       = 1'b0;
      dir_wa       = dir_ff;
      dir_wd       = perm_ff;
      tbl_we       = 1'b0;
      tbl_re       = 1'b0;
      tbl_wa       = addr_ff;
      tbl_wd       = '{frame: frame_ff, perm: perm_ff};
      hit          = 1'b0;

      // response beat leaves the output register
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         // sweep the directory to not present after reset
         S_INIT: begin
            dir_we      = 1'b1;
            dir_wa      = init_ptr_ff;
            dir_wd      = '0;
            init_ptr_in = init_ptr_ff + 1'b1;
            if (init_ptr_ff == DIR_LAST) begin
               state_in = S_IDLE;
            end
         end
         // take a request beat; unmap becomes map with zero frame and flags
         S_IDLE: begin
            if (req_valid) begin
               act_in = action_type'(req_action);
               vpn_in = req_virt_addr[VA_W-1:OFF_W];
               off_in = req_virt_addr[OFF_W-1:0];
               if (action_type'(req_action) == ACT_UNMAP) begin
                  frame_in = '0;
                  perm_in  = '0;
               end else begin
                  frame_in = req_phys_page[PA_W-1:OFF_W];
                  perm_in  = '{user: req_flags[FLAG_USER],
                               present: req_flags[FLAG_PRESENT]};
               end
               state_in = S_DIV1;
            end
         end
         // page number / TABLE_ENTRIES
         S_DIV1: begin
            mul_a    = vpn_ff;
            mul_b    = T_RECIP_C;
            q1_in    = VPN_W'(prod >> T_SHIFT);
            state_in = S_REM1;
         end
         // table index = page number - quotient * TABLE_ENTRIES
         S_REM1: begin
            mul_a    = q1_ff;
            mul_b    = T_CNT_C;
            tab_in   = diff[TAB_W-1:0];
            state_in = S_DIV2;
         end
         // quotient / DIR_ENTRIES
         S_DIV2: begin
            mul_a    = q1_ff;
            mul_b    = D_RECIP_C;
            q2_in    = VPN_W'(prod >> D_SHIFT);
            state_in = S_REM2;
         end
         // directory index wraps modulo DIR_ENTRIES
         S_REM2: begin
            mul_a    = q2_ff;
            mul_b    = D_CNT_C;
            dir_in   = DIR_W'(q1_ff - prod[VPN_W-1:0]);
            state_in = S_ADDR;
         end
         // table memory address and directory read
         S_ADDR: begin
            mul_a      = VPN_W'(dir_ff);
            mul_b      = T_CNT_C;
            addr_in    = base + ADDR_W'(tab_ff);
            clr_ptr_in = base;
            clr_cnt_in = '0;
            dir_re     = 1'b1;
            state_in   = S_LOOK;
         end
         // directory entry is in; branch on the action
         S_LOOK: begin
            case (act_ff)
               ACT_MAP, ACT_UNMAP: begin
                  if (!dir_rd_ff.present) begin
                     dir_we   = 1'b1;
                     state_in = S_CLEAR;
                  end else begin
                     state_in = S_WRITE;
                  end
               end
               default: begin
                  tbl_re   = 1'b1;
                  state_in = S_TRD;
               end
            endcase
         end
         // table entry is in; form the response once the output register is free
         S_TRD: begin
            if (!rsp_valid_ff || rsp_ready) begin
               if (act_ff == ACT_XLATE) begin
                  hit       = dir_rd_ff.present && tbl_rd_ff.perm.present;
                  rsp_pa_in = hit ? {tbl_rd_ff.frame, off_ff} : '0;
                  rsp_um_in = 1'b0;
               end else begin
                  rsp_pa_in = '0;
                  rsp_um_in = dir_rd_ff.present && dir_rd_ff.user &&
                              tbl_rd_ff.perm.present && tbl_rd_ff.perm.user;
               end
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         // zero the new table, one entry per cycle
         S_CLEAR: begin
            tbl_we     = 1'b1;
            tbl_wa     = clr_ptr_ff;
            tbl_wd     = '0;
            clr_ptr_in = clr_ptr_ff + 1'b1;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == TAB_LAST) begin
               state_in = S_WRITE;
            end
         end
         // write the mapped entry
         S_WRITE: begin
            tbl_we   = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
         init_ptr_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         init_ptr_ff  <= init_ptr_in;
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      act_ff     <= act_in;
      vpn_ff     <= vpn_in;
      off_ff     <= off_in;
      frame_ff   <= frame_in;
      perm_ff    <= perm_in;
      q1_ff      <= q1_in;
      q2_ff      <= q2_in;
      tab_ff     <= tab_in;
      dir_ff     <= dir_in;
      addr_ff    <= addr_in;
      clr_ptr_ff <= clr_ptr_in;
      clr_cnt_ff <= clr_cnt_in;
      rsp_pa_ff  <= rsp_pa_in;
      rsp_um_ff  <= rsp_um_in;
   end

   // directory memory, registered read
   always_ff @(posedge clock) begin
      if (dir_we) begin
         dir_mem[dir_wa] <= dir_wd;
      end
      if (dir_re) begin
         dir_rd_ff <= dir_mem[dir_ff];
      end
   end

   // table memory, registered read
   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[tbl_wa] <= tbl_wd;
      end
      if (tbl_re) begin
         tbl_rd_ff <= tbl_mem[addr_ff];
      end
   end

   // split of the page number lands inside both index ranges
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ADDR) |->
         (int'(dir_ff) < DIR_ENTRIES) && (int'(tab_ff) < TABLE_ENTRIES))
      else $error("page number split out of range");

   // table writes stay inside the memory
   a_write_range: assert property (@(posedge clock) disable iff (reset)
      tbl_we |-> (int'(tbl_wa) < TBL_DEPTH))
      else $error("table write address out of range");

   // a table is only cleared for a directory entry that was absent
   a_clear_absent: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !dir_rd_ff.present)
      else $error("clearing a table that is present");

   // the clear sweep ends in the entry write
   a_clear_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR && clr_cnt_ff == TAB_LAST) |=> (state_ff == S_WRITE))
      else $error("clear sweep did not end in the entry write");

   // a response beat only comes out of the table read step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_TRD))
      else $error("response raised outside the table read step");

endmodule
